// ===== src/sfla_pkg.sv =====
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types and constants for the fixed-point lane ALU: operation codes,
// per-item control word and lane word type.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int LANE_W      = 16;
  localparam int SLOT_COUNT  = 4;
  localparam int GROUP_COUNT = 8;
  localparam int GROUP_W     = 3;
  localparam int FRAC_W      = 4;
  localparam int ITEM_W      = SLOT_COUNT * LANE_W;
  localparam int PROD_W      = 2 * LANE_W;

  typedef logic [LANE_W-1:0] word_t;

  typedef enum logic [3:0] {
    FN_ADD     = 4'd0,
    FN_SUB     = 4'd1,
    FN_MUL     = 4'd2,
    FN_MUL_RN  = 4'd3,
    FN_MUL_SR  = 4'd4,
    FN_SAMPLE  = 4'd5,
    FN_SEED    = 4'd6,
    FN_EQ      = 4'd7,
    FN_NE      = 4'd8,
    FN_LT      = 4'd9,
    FN_GE      = 4'd10
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [FRAC_W-1:0]  frac;
    logic               sat;
  } ctl_t;

endpackage

// ===== src/sfla_rng_bank.sv =====
// ----------------------------------------------------------------------------
// sfla_rng_bank
// Row of per-lane xoroshiro32++ generator cells. Each cell computes its own
// draw and next state; the lane group picks which cells feed the item slots.
// ----------------------------------------------------------------------------
module sfla_rng_bank #(
  parameter int LANE_COUNT     = 32,
  parameter int LANES_PER_ITEM = 4
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  accept,
  input  sfla_pkg::func_t                                       func,
  input  logic [sfla_pkg::GROUP_W-1:0]                          group,
  input  logic [sfla_pkg::ITEM_W-1:0]                           a_lanes,
  input  logic [sfla_pkg::ITEM_W-1:0]                           b_lanes,
  output logic [sfla_pkg::SLOT_COUNT-1:0][sfla_pkg::LANE_W-1:0] slot_rnd
);

  localparam int ROT_SUM  = 9;
  localparam int ROT_S0   = 13;
  localparam int SHIFT_S1 = 5;
  localparam int ROT_S1   = 10;

  function automatic sfla_pkg::word_t rotl(sfla_pkg::word_t x, int unsigned k);
    return (x << k) | (x >> (sfla_pkg::LANE_W - k));
  endfunction

  sfla_pkg::word_t lo_r [LANE_COUNT];
  sfla_pkg::word_t hi_r [LANE_COUNT];
  sfla_pkg::word_t cell_rnd [LANE_COUNT];
  sfla_pkg::word_t lo_adv [LANE_COUNT];
  sfla_pkg::word_t hi_adv [LANE_COUNT];
  sfla_pkg::word_t seed_lo [LANE_COUNT];
  sfla_pkg::word_t seed_hi [LANE_COUNT];
  logic [LANE_COUNT-1:0] cell_hit;

  logic [LANE_COUNT-1:0] lane_oh [sfla_pkg::SLOT_COUNT][sfla_pkg::GROUP_COUNT];
  sfla_pkg::word_t       grp_rnd [sfla_pkg::SLOT_COUNT][sfla_pkg::GROUP_COUNT];
  logic [LANE_COUNT-1:0] slot_oh [sfla_pkg::SLOT_COUNT];

  logic do_draw;
  logic do_seed;

  assign do_draw = accept && (func == sfla_pkg::FN_MUL_SR || func == sfla_pkg::FN_SAMPLE);
  assign do_seed = accept && (func == sfla_pkg::FN_SEED);

  for (genvar l = 0; l < LANE_COUNT; l++) begin : g_cell
    sfla_pkg::word_t mix;
    sfla_pkg::word_t sum;
    assign mix         = lo_r[l] ^ hi_r[l];
    assign sum         = lo_r[l] + hi_r[l];
    assign cell_rnd[l] = rotl(sum, ROT_SUM) + lo_r[l];
    assign lo_adv[l]   = rotl(lo_r[l], ROT_S0) ^ mix ^ (mix << SHIFT_S1);
    assign hi_adv[l]   = rotl(mix, ROT_S1);
  end

  // lane of slot i in group g is fixed at elaboration, wrapping over the lane count
  for (genvar i = 0; i < sfla_pkg::SLOT_COUNT; i++) begin : g_slot
    for (genvar g = 0; g < sfla_pkg::GROUP_COUNT; g++) begin : g_grp
      if (i < LANES_PER_ITEM) begin : g_used
        localparam int LIDX = (g * LANES_PER_ITEM + i) % LANE_COUNT;
        assign lane_oh[i][g] = LANE_COUNT'(1) << LIDX;
        assign grp_rnd[i][g] = cell_rnd[LIDX];
      end else begin : g_unused
        assign lane_oh[i][g] = '0;
        assign grp_rnd[i][g] = '0;
      end
    end
    assign slot_oh[i]  = lane_oh[i][group];
    assign slot_rnd[i] = grp_rnd[i][group];
  end

  // slots of one item land on distinct lanes as long as LANE_COUNT is at least LANES_PER_ITEM
  always_comb begin
    for (int l = 0; l < LANE_COUNT; l++) begin
      cell_hit[l] = 1'b0;
      seed_lo[l]  = '0;
      seed_hi[l]  = '0;
      for (int i = 0; i < sfla_pkg::SLOT_COUNT; i++) begin
        if (slot_oh[i][l]) begin
          cell_hit[l] = 1'b1;
          seed_lo[l]  = a_lanes[i*sfla_pkg::LANE_W +: sfla_pkg::LANE_W];
          seed_hi[l]  = b_lanes[i*sfla_pkg::LANE_W +: sfla_pkg::LANE_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LANE_COUNT; l++) begin
        lo_r[l] <= '0;
        hi_r[l] <= '0;
      end
    end else begin
      for (int l = 0; l < LANE_COUNT; l++) begin
        if (cell_hit[l] && do_seed) begin
          lo_r[l] <= seed_lo[l];
          hi_r[l] <= seed_hi[l];
        end else if (cell_hit[l] && do_draw) begin
          lo_r[l] <= lo_adv[l];
          hi_r[l] <= hi_adv[l];
        end
      end
    end
  end

endmodule

// ===== src/sfla_lane.sv =====
// ----------------------------------------------------------------------------
// sfla_lane
// One 16-bit lane datapath: multiply or add/sub and compare into a stage
// register, then rounding offset, arithmetic shift and clamp.
// ----------------------------------------------------------------------------
module sfla_lane (
  input  logic            clk,
  input  logic            load,
  input  sfla_pkg::ctl_t  s1_ctl,
  input  sfla_pkg::word_t a,
  input  sfla_pkg::word_t b,
  input  sfla_pkg::word_t rnd,
  input  sfla_pkg::ctl_t  s2_ctl,
  output sfla_pkg::word_t lane_res,
  output logic            hit
);

  logic signed [sfla_pkg::LANE_W-1:0] a_s;
  logic signed [sfla_pkg::LANE_W-1:0] b_s;
  logic signed [sfla_pkg::PROD_W-1:0] prod;
  logic signed [sfla_pkg::PROD_W-1:0] pre_nxt;
  logic signed [sfla_pkg::PROD_W-1:0] pre_r;
  sfla_pkg::word_t                    off_nxt;
  sfla_pkg::word_t                    off_r;
  logic [sfla_pkg::LANE_W-2:0]        smp_r;
  logic                               hit_nxt;
  logic                               hit_r;
  sfla_pkg::word_t                    half;
  sfla_pkg::word_t                    frac_mask;

  logic signed [sfla_pkg::PROD_W-1:0] sum;
  logic signed [sfla_pkg::PROD_W-1:0] shifted;
  logic [sfla_pkg::FRAC_W-1:0]        shamt;
  sfla_pkg::word_t                    fin;

  assign a_s  = $signed(a);
  assign b_s  = $signed(b);
  assign prod = a_s * b_s;

  assign half      = (s1_ctl.frac == '0) ? '0 :
                     (sfla_pkg::word_t'(1) << (s1_ctl.frac - sfla_pkg::FRAC_W'(1)));
  assign frac_mask = (sfla_pkg::word_t'(1) << s1_ctl.frac) - sfla_pkg::word_t'(1);

  always_comb begin
    pre_nxt = '0;
    off_nxt = '0;
    hit_nxt = 1'b0;
    case (s1_ctl.func)
      sfla_pkg::FN_ADD:    pre_nxt = sfla_pkg::PROD_W'(a_s) + sfla_pkg::PROD_W'(b_s);
      sfla_pkg::FN_SUB:    pre_nxt = sfla_pkg::PROD_W'(a_s) - sfla_pkg::PROD_W'(b_s);
      sfla_pkg::FN_MUL:    pre_nxt = prod;
      sfla_pkg::FN_MUL_RN: begin
        pre_nxt = prod;
        off_nxt = half;
      end
      sfla_pkg::FN_MUL_SR: begin
        pre_nxt = prod;
        off_nxt = rnd & frac_mask;
      end
      sfla_pkg::FN_EQ:     hit_nxt = (a_s == b_s);
      sfla_pkg::FN_NE:     hit_nxt = (a_s != b_s);
      sfla_pkg::FN_LT:     hit_nxt = (a_s < b_s);
      sfla_pkg::FN_GE:     hit_nxt = (a_s >= b_s);
      default: begin
        pre_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pre_r <= pre_nxt;
      off_r <= off_nxt;
      smp_r <= rnd[sfla_pkg::LANE_W-1:1];
      hit_r <= hit_nxt;
    end
  end

  // only the multiplies shift; add and subtract pass through unshifted
  assign shamt   = (s2_ctl.func == sfla_pkg::FN_MUL || s2_ctl.func == sfla_pkg::FN_MUL_RN ||
                    s2_ctl.func == sfla_pkg::FN_MUL_SR) ? s2_ctl.frac : '0;
  assign sum     = pre_r + $signed({{(sfla_pkg::PROD_W-sfla_pkg::LANE_W){1'b0}}, off_r});
  assign shifted = sum >>> shamt;

  always_comb begin
    if (s2_ctl.sat && shifted > sfla_pkg::PROD_W'(32767)) begin
      fin = 16'h7fff;
    end else if (s2_ctl.sat && shifted < -sfla_pkg::PROD_W'(32768)) begin
      fin = 16'h8000;
    end else begin
      fin = shifted[sfla_pkg::LANE_W-1:0];
    end
  end

  always_comb begin
    case (s2_ctl.func)
      sfla_pkg::FN_ADD,
      sfla_pkg::FN_SUB,
      sfla_pkg::FN_MUL,
      sfla_pkg::FN_MUL_RN,
      sfla_pkg::FN_MUL_SR: lane_res = fin;
      sfla_pkg::FN_SAMPLE: lane_res = {1'b0, smp_r};
      default:             lane_res = '0;
    endcase
  end

  assign hit = hit_r;

endmodule

// ===== src/sfla_merge.sv =====
// ----------------------------------------------------------------------------
// sfla_merge
// Output stage: packs the lane results and compare bits into one result
// item and holds it until the consumer takes it.
// ----------------------------------------------------------------------------
module sfla_merge (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  load,
  input  logic [sfla_pkg::SLOT_COUNT-1:0][sfla_pkg::LANE_W-1:0] lane_res,
  input  logic [sfla_pkg::SLOT_COUNT-1:0]                       lane_hit,
  input  logic                                                  out_stall,
  output logic                                                  out_valid,
  output logic [sfla_pkg::ITEM_W-1:0]                           out_result_lanes,
  output logic [sfla_pkg::SLOT_COUNT-1:0]                       out_compare_mask
);

  logic                               valid_r;
  logic [sfla_pkg::ITEM_W-1:0]        res_r;
  logic [sfla_pkg::SLOT_COUNT-1:0]    mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= lane_res;
      mask_r <= lane_hit;
    end
  end

  assign out_valid        = valid_r;
  assign out_result_lanes = res_r;
  assign out_compare_mask = mask_r;

endmodule

// ===== src/simd_fixed_point_lane_alu_unit.sv =====
// ----------------------------------------------------------------------------
// simd_fixed_point_lane_alu_unit
// Four-lane 16-bit fixed-point ALU with per-lane xoroshiro32++ generators
// for stochastic rounding, random samples and lane compares.
//
//   port group | dir | handshake          | payload
//   -----------+-----+--------------------+----------------------------------
//   in_*       | in  | in_valid/in_stall  | func, lane_group, a/b lanes, frac
//   out_*      | out | out_valid/out_stall| result_lanes, compare_mask
//
// one item per cycle sustained while the output is not stalled; from acceptance to
// out_valid an item passes the input register, multiply stage and round/clamp into the output register
// the item's generator cells draw or load a seed at the accepting edge, so the next item already
// sees the new state; reset clears every generator to zero
// in_stall rises only when all three stages hold items and the output stalls
// ----------------------------------------------------------------------------
module simd_fixed_point_lane_alu_unit #(
  parameter int LANE_COUNT     = 32,
  parameter int LANES_PER_ITEM = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [3:0]                            in_func,
  input  logic [sfla_pkg::GROUP_W-1:0]          in_lane_group,
  input  logic [sfla_pkg::ITEM_W-1:0]           in_a_lanes,
  input  logic [sfla_pkg::ITEM_W-1:0]           in_b_lanes,
  input  logic [sfla_pkg::FRAC_W-1:0]           in_frac_bits,
  input  logic                                  in_saturate,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [sfla_pkg::ITEM_W-1:0]           out_result_lanes,
  output logic [sfla_pkg::SLOT_COUNT-1:0]       out_compare_mask
);

  sfla_pkg::ctl_t in_ctl;
  logic           accept;
  logic           adv1;
  logic           adv2;
  logic           out_free;
  logic           s2_free;
  logic           s1_free;

  logic           s1_v_r;
  sfla_pkg::ctl_t s1_ctl_r;
  logic [sfla_pkg::ITEM_W-1:0] s1_a_r;
  logic [sfla_pkg::ITEM_W-1:0] s1_b_r;
  logic [sfla_pkg::SLOT_COUNT-1:0][sfla_pkg::LANE_W-1:0] s1_rnd_r;
  logic           s2_v_r;
  sfla_pkg::ctl_t s2_ctl_r;

  logic [sfla_pkg::SLOT_COUNT-1:0][sfla_pkg::LANE_W-1:0] slot_rnd;
  logic [sfla_pkg::SLOT_COUNT-1:0][sfla_pkg::LANE_W-1:0] lane_res;
  logic [sfla_pkg::SLOT_COUNT-1:0]                       lane_hit;

  assign in_ctl.func = sfla_pkg::func_t'(in_func);
  assign in_ctl.frac = in_frac_bits;
  assign in_ctl.sat  = in_saturate;

  // each stage moves on when the next one is empty or moving too
  assign out_free = !out_valid || !out_stall;
  assign adv2     = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || adv2;
  assign adv1     = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || adv1;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  sfla_rng_bank #(
    .LANE_COUNT     (LANE_COUNT),
    .LANES_PER_ITEM (LANES_PER_ITEM)
  ) u_rng (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .func     (in_ctl.func),
    .group    (in_lane_group),
    .a_lanes  (in_a_lanes),
    .b_lanes  (in_b_lanes),
    .slot_rnd (slot_rnd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (adv1) begin
        s1_v_r <= 1'b0;
      end
      if (adv1) begin
        s2_v_r <= 1'b1;
      end else if (adv2) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= in_ctl;
      s1_a_r   <= in_a_lanes;
      s1_b_r   <= in_b_lanes;
      s1_rnd_r <= slot_rnd;
    end
    if (adv1) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  for (genvar i = 0; i < sfla_pkg::SLOT_COUNT; i++) begin : g_lane
    if (i < LANES_PER_ITEM) begin : g_used
      sfla_lane u_lane (
        .clk      (clk),
        .load     (adv1),
        .s1_ctl   (s1_ctl_r),
        .a        (s1_a_r[i*sfla_pkg::LANE_W +: sfla_pkg::LANE_W]),
        .b        (s1_b_r[i*sfla_pkg::LANE_W +: sfla_pkg::LANE_W]),
        .rnd      (s1_rnd_r[i]),
        .s2_ctl   (s2_ctl_r),
        .lane_res (lane_res[i]),
        .hit      (lane_hit[i])
      );
    end else begin : g_unused
      assign lane_res[i] = '0;
      assign lane_hit[i] = 1'b0;
    end
  end

  sfla_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (adv2),
    .lane_res         (lane_res),
    .lane_hit         (lane_hit),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_result_lanes (out_result_lanes),
    .out_compare_mask (out_compare_mask)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && out_valid))
    else $error("input stalled with a free pipeline stage");

  a_adv_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    adv2 |=> out_valid)
    else $error("item lost between lane stage and output register");

  a_mask_excludes_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_compare_mask != '0) |-> (out_result_lanes == '0))
    else $error("compare item carries non-zero lane results");

endmodule

// ===== tb/simd_fixed_point_lane_alu_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simd_fixed_point_lane_alu_unit_tb
// Checks the four-lane fixed-point ALU against an in-bench model of its
// arithmetic, compares and per-lane xoroshiro32++ generators. A short table
// of edge cases runs first, then about a thousand random items with random
// idling on both channels, a long calm stretch and one full drain mid-run.
// ----------------------------------------------------------------------------
module simd_fixed_point_lane_alu_unit_tb;

  localparam int LANES       = 32;
  localparam int DIRECTED_N  = 25;
  localparam int RANDOM_N    = 1030;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;

  // funcs outside the decoded set
  localparam logic [3:0] FN_SPARE_LO = 4'd11;
  localparam logic [3:0] FN_SPARE_HI = 4'd15;

  localparam logic [63:0] NONE    = 64'h0;
  localparam logic [63:0] ALL_MIN = {4{16'h8000}};
  localparam logic [63:0] ALL_ONE = {4{16'hFFFF}};
  localparam logic [63:0] EDGE_A  = 64'h8000_7FFF_8000_7FFF;
  localparam logic [63:0] EDGE_B  = 64'h8000_7FFF_FFFF_0001;
  localparam logic [63:0] CMP_A   = 64'h0001_0005_FFFF_1234;
  localparam logic [63:0] CMP_B   = 64'h0002_0005_FFFE_1234;
  localparam logic [63:0] ORD_A   = 64'h8000_0000_7FFF_FFFF;
  localparam logic [63:0] ORD_B   = 64'h7FFF_0000_8000_0000;

  typedef struct packed {
    logic [3:0]  fn;
    logic [2:0]  grp;
    logic [63:0] a;
    logic [63:0] b;
    logic [3:0]  frac;
    logic        sat;
    logic        typed;
    logic [63:0] res;
    logic [3:0]  mask;
  } stim_row_t;

  typedef struct packed {
    logic [63:0] lanes;
    logic [3:0]  mask;
  } lane_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_func = '0;
  logic [2:0]  in_lane_group = '0;
  logic [63:0] in_a_lanes = '0;
  logic [63:0] in_b_lanes = '0;
  logic [3:0]  in_frac_bits = '0;
  logic        in_saturate = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result_lanes;
  logic [3:0]  out_compare_mask;

  sfla_pkg::word_t gen_lo [LANES];
  sfla_pkg::word_t gen_hi [LANES];
  lane_result_t    pending_results [$];
  int              mismatch_count = 0;
  int              cycle_count = 0;
  logic            calm = 1'b0;

  stim_row_t directed_rows [DIRECTED_N] = '{
    '{sfla_pkg::FN_SAMPLE, 3'd0, NONE, NONE, 4'd0, 1'b0, 1'b1, NONE, 4'h0},
    '{sfla_pkg::FN_MUL_SR, 3'd1, 64'h7FFF_8000_7FFF_8000, 64'h7FFF_8000_8000_7FFF, 4'd15, 1'b0,
      1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_ADD, 3'd0, EDGE_A, EDGE_B, 4'd0, 1'b1, 1'b1, 64'h8000_7FFF_8000_7FFF, 4'h0},
    '{sfla_pkg::FN_ADD, 3'd0, EDGE_A, EDGE_B, 4'd0, 1'b0, 1'b1, 64'h0000_FFFE_7FFF_8000, 4'h0},
    '{sfla_pkg::FN_SUB, 3'd2, EDGE_A, EDGE_B, 4'd3, 1'b1, 1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_SUB, 3'd2, 64'h8000_8000_7FFF_7FFF, 64'h7FFF_7FFF_8000_8000, 4'd0, 1'b0,
      1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_SUB, 3'd2, 64'h8000_8000_7FFF_7FFF, 64'h7FFF_7FFF_8000_8000, 4'd0, 1'b1,
      1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_MUL, 3'd0, ALL_MIN, ALL_MIN, 4'd0, 1'b1, 1'b1, {4{16'h7FFF}}, 4'h0},
    '{sfla_pkg::FN_MUL, 3'd0, ALL_MIN, ALL_MIN, 4'd15, 1'b0, 1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_MUL_RN, 3'd4, 64'h0003_FFFD_0007_FFFF, 64'h0005_0003_FFF9_0001, 4'd0, 1'b0,
      1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_MUL_RN, 3'd4, 64'h8000_7FFF_C000_0001, 64'h7FFF_7FFF_0001_FFFF, 4'd15, 1'b1,
      1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_MUL, 3'd5, 64'hFF38_00C8_FFF3_0011, 64'h0007_FFF9_0013_FFED, 4'd4, 1'b0,
      1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_SEED, 3'd0, 64'h1234_0001_ACE1_BEEF, 64'h0000_8000_FFFF_0001, 4'd9, 1'b1,
      1'b1, NONE, 4'h0},
    '{sfla_pkg::FN_SAMPLE, 3'd0, ALL_ONE, ALL_ONE, 4'd0, 1'b1, 1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_MUL_SR, 3'd0, 64'h0123_FEDC_4567_BA98, 64'h0F0F_F0F0_3333_CCCC, 4'd8, 1'b0,
      1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_SEED, 3'd7, ALL_ONE, ALL_ONE, 4'd0, 1'b0, 1'b1, NONE, 4'h0},
    '{sfla_pkg::FN_SAMPLE, 3'd7, NONE, NONE, 4'd0, 1'b0, 1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_MUL_SR, 3'd7, ALL_MIN, ALL_MIN, 4'd0, 1'b1, 1'b0, NONE, 4'h0},
    '{sfla_pkg::FN_EQ, 3'd1, CMP_A, CMP_B, 4'd0, 1'b0, 1'b1, NONE, 4'b0101},
    '{sfla_pkg::FN_NE, 3'd1, CMP_A, CMP_B, 4'd15, 1'b1, 1'b1, NONE, 4'b1010},
    '{sfla_pkg::FN_LT, 3'd6, ORD_A, ORD_B, 4'd0, 1'b0, 1'b1, NONE, 4'b1001},
    '{sfla_pkg::FN_GE, 3'd6, ORD_A, ORD_B, 4'd7, 1'b1, 1'b1, NONE, 4'b0110},
    '{FN_SPARE_LO, 3'd0, EDGE_A, EDGE_B, 4'd5, 1'b0, 1'b1, NONE, 4'h0},
    '{FN_SPARE_HI, 3'd7, ALL_ONE, ALL_ONE, 4'd15, 1'b1, 1'b1, NONE, 4'h0},
    '{sfla_pkg::FN_SAMPLE, 3'd3, ALL_ONE, NONE, 4'd0, 1'b0, 1'b1, NONE, 4'h0}
  };

  simd_fixed_point_lane_alu_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_lane_group    (in_lane_group),
    .in_a_lanes       (in_a_lanes),
    .in_b_lanes       (in_b_lanes),
    .in_frac_bits     (in_frac_bits),
    .in_saturate      (in_saturate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_lanes (out_result_lanes),
    .out_compare_mask (out_compare_mask)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // xoroshiro32++ output, then advance that lane's generator
  function automatic sfla_pkg::word_t gen_draw(input int lane);
    sfla_pkg::word_t s0, s1, sum, draw;
    s0 = gen_lo[lane];
    s1 = gen_hi[lane];
    sum = s0 + s1;
    draw = {sum[6:0], sum[15:7]} + s0;
    s1 = s1 ^ s0;
    s0 = {s0[2:0], s0[15:3]} ^ s1 ^ (s1 << 5);
    s1 = {s1[5:0], s1[15:6]};
    gen_lo[lane] = s0;
    gen_hi[lane] = s1;
    return draw;
  endfunction

  function automatic sfla_pkg::word_t fit_lane(input logic signed [33:0] v, input logic sat);
    if (sat && v > 34'sd32767) return 16'h7FFF;
    if (sat && v < -34'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic lane_result_t lane_alu_outcome(input stim_row_t row);
    lane_result_t got;
    int lane;
    int i;
    logic signed [15:0] x, y;
    logic signed [33:0] xs, ys, prod, bias;
    sfla_pkg::word_t lv, draw;
    got = '0;
    for (i = 0; i < sfla_pkg::SLOT_COUNT; i++) begin
      lane = (row.grp * sfla_pkg::SLOT_COUNT + i) % LANES;
      x = row.a[16*i +: 16];
      y = row.b[16*i +: 16];
      xs = x;
      ys = y;
      prod = xs * ys;
      lv = '0;
      case (row.fn)
        sfla_pkg::FN_ADD: lv = fit_lane(xs + ys, row.sat);
        sfla_pkg::FN_SUB: lv = fit_lane(xs - ys, row.sat);
        sfla_pkg::FN_MUL: lv = fit_lane(prod >>> row.frac, row.sat);
        sfla_pkg::FN_MUL_RN: begin
          // no half-step offset when there are no fraction bits
          bias = (row.frac == 0) ? 34'sd0 : (34'sd1 <<< (row.frac - 1));
          lv = fit_lane((prod + bias) >>> row.frac, row.sat);
        end
        sfla_pkg::FN_MUL_SR: begin
          draw = gen_draw(lane);
          bias = {18'd0, draw & ((16'h1 << row.frac) - 16'h1)};
          lv = fit_lane((prod + bias) >>> row.frac, row.sat);
        end
        sfla_pkg::FN_SAMPLE: lv = gen_draw(lane) >> 1;
        sfla_pkg::FN_SEED: begin
          gen_lo[lane] = row.a[16*i +: 16];
          gen_hi[lane] = row.b[16*i +: 16];
        end
        sfla_pkg::FN_EQ: got.mask[i] = (x == y);
        sfla_pkg::FN_NE: got.mask[i] = (x != y);
        sfla_pkg::FN_LT: got.mask[i] = (x < y);
        sfla_pkg::FN_GE: got.mask[i] = (x >= y);
        default: ;
      endcase
      got.lanes[16*i +: 16] = lv;
    end
    return got;
  endfunction

  // half full-range values, with the signed extremes, zero, all ones and small values mixed in
  function automatic logic [63:0] pick_lanes();
    logic [63:0] v;
    int i;
    for (i = 0; i < sfla_pkg::SLOT_COUNT; i++) begin
      case ($urandom_range(9))
        0: v[16*i +: 16] = 16'h7FFF;
        1: v[16*i +: 16] = 16'h8000;
        2: v[16*i +: 16] = 16'h0000;
        3: v[16*i +: 16] = 16'hFFFF;
        4: v[16*i +: 16] = 16'($urandom_range(255)) - 16'd128;
        default: v[16*i +: 16] = 16'($urandom);
      endcase
    end
    return v;
  endfunction

  function automatic stim_row_t random_row(input int n);
    stim_row_t row;
    int roll;
    row = '0;
    row.grp  = 3'($urandom_range(7));
    row.a    = pick_lanes();
    row.b    = pick_lanes();
    row.frac = 4'($urandom_range(15));
    row.sat  = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (n < sfla_pkg::GROUP_COUNT) begin
      // seed every group first so the generators are live
      row.fn  = sfla_pkg::FN_SEED;
      row.grp = 3'(n);
      row.a   = {$urandom, $urandom};
      row.b   = {$urandom, $urandom};
    end else if (roll < 12) row.fn = sfla_pkg::FN_ADD;
    else if (roll < 22) row.fn = sfla_pkg::FN_SUB;
    else if (roll < 34) row.fn = sfla_pkg::FN_MUL;
    else if (roll < 46) row.fn = sfla_pkg::FN_MUL_RN;
    else if (roll < 62) row.fn = sfla_pkg::FN_MUL_SR;
    else if (roll < 72) row.fn = sfla_pkg::FN_SAMPLE;
    else if (roll < 78) row.fn = sfla_pkg::FN_SEED;
    else if (roll < 94) row.fn = 4'($urandom_range(sfla_pkg::FN_GE, sfla_pkg::FN_EQ));
    else row.fn = 4'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
    return row;
  endfunction

  task automatic offer_item(input stim_row_t row, input logic drain_after);
    lane_result_t want;
    in_valid      <= 1'b1;
    in_func       <= row.fn;
    in_lane_group <= row.grp;
    in_a_lanes    <= row.a;
    in_b_lanes    <= row.b;
    in_frac_bits  <= row.frac;
    in_saturate   <= row.sat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = lane_alu_outcome(row);
    if (row.typed) begin
      want.lanes = row.res;
      want.mask  = row.mask;
    end
    pending_results.push_back(want);
    if (drain_after) begin
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end else if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 16);
  end

  always @(posedge clk) begin
    lane_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item, expected none got %h / %h", $time,
                 out_result_lanes, out_compare_mask);
      end else begin
        want = pending_results.pop_front();
        if (out_result_lanes !== want.lanes) begin
          mismatch_count++;
          $display("%0t: result_lanes expected %h got %h", $time, want.lanes,
                   out_result_lanes);
        end
        if (out_compare_mask !== want.mask) begin
          mismatch_count++;
          $display("%0t: compare_mask expected %b got %b", $time, want.mask,
                   out_compare_mask);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    int n;
    for (i = 0; i < LANES; i++) begin
      gen_lo[i] = '0;
      gen_hi[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < DIRECTED_N; i++) offer_item(directed_rows[i], 1'b0);
    for (n = 0; n < RANDOM_N; n++) begin
      calm = (n >= 300 && n < 450);
      // one full drain part-way through, and the last one at the end
      offer_item(random_row(n), (n == 600) || (n == RANDOM_N - 1));
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
